@@ rtl/owf_pkg.sv @@
// ----------------------------------------------------------------------------
// owf_pkg
// Shared types and constants for the overlapping window framer.
// ----------------------------------------------------------------------------
package owf_pkg;

  localparam int WINDOW_MAX   = 64;
  localparam int MAX_CHANNELS = 4;
  localparam int WORD_BITS    = 32;
  localparam int IN_WORDS     = 4;

  localparam int PTR_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = PTR_W + 1;
  localparam int SAMPLE_W   = IN_WORDS * WORD_BITS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int NCH_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOP        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] WINDOW_LEN_RST = 7'd64;
  localparam logic [CFG_DATA_W-1:0] HOP_RST        = 7'd32;
  localparam logic [NCH_W-1:0]      CHANNELS_RST   = 3'd1;

  // one window to read out: start slot and length
  typedef struct packed {
    logic [PTR_W-1:0] base;
    logic [CNT_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic [1:0] count;
    cmd_t       e0;
    cmd_t       e1;
  } q_status_t;

  typedef struct packed {
    logic                en;
    logic [PTR_W-1:0]    addr;
    logic [SAMPLE_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] data;
    logic [PTR_W-1:0]    pos;
    logic                last;
  } beat_t;

endpackage

@@ rtl/owf_ram.sv @@
// ----------------------------------------------------------------------------
// owf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module owf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/owf_front.sv @@
// ----------------------------------------------------------------------------
// owf_front
// Config registers, sample accept, ring bookkeeping and window detection.
// ----------------------------------------------------------------------------
module owf_front import owf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WORD_BITS-1:0]  ch0_in,
  input  logic [WORD_BITS-1:0]  ch1_in,
  input  logic [WORD_BITS-1:0]  ch2_in,
  input  logic [WORD_BITS-1:0]  ch3_in,
  input  q_status_t             q_stat,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  output ram_wr_t               ram_wr
);

  logic [CFG_DATA_W-1:0] window_len;
  logic [CFG_DATA_W-1:0] hop;
  logic [NCH_W-1:0]      channels;
  logic [PTR_W-1:0]      head;
  logic [CNT_W-1:0]      fill;
  logic [PTR_W-1:0]      head_next;
  logic [CNT_W-1:0]      fill_next;

  logic                  accept;
  logic [PTR_W-1:0]      head_a;
  logic [CNT_W-1:0]      fill_a;
  logic [CNT_W-1:0]      fill_b;
  logic [CNT_W-1:0]      win;
  logic [NCH_W-1:0]      nch;
  logic [PTR_W-1:0]      wslot;
  logic [PTR_W-1:0]      diff0;
  logic [PTR_W-1:0]      diff1;
  logic                  hit;
  logic                  done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RST;
      hop        <= HOP_RST;
      channels   <= CHANNELS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW_LEN: window_len <= cfg_data;
        REG_HOP:        hop        <= cfg_data;
        REG_CHANNELS:   channels   <= cfg_data[NCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fill == CNT_W'(WINDOW_MAX)) begin
      head_a = head + PTR_W'(1);
      fill_a = CNT_W'(WINDOW_MAX - 1);
    end else begin
      head_a = head;
      fill_a = fill;
    end
    fill_b = fill_a + CNT_W'(1);
    wslot  = head_a + fill_a[PTR_W-1:0];

    if (window_len == '0) begin
      win = CNT_W'(1);
    end else if (window_len > CFG_DATA_W'(WINDOW_MAX)) begin
      win = CNT_W'(WINDOW_MAX);
    end else begin
      win = window_len;
    end

    if (channels == '0) begin
      nch = NCH_W'(1);
    end else if (channels > NCH_W'(MAX_CHANNELS)) begin
      nch = NCH_W'(MAX_CHANNELS);
    end else begin
      nch = channels;
    end

    // stall while the write slot lies in a window not yet read out or two windows are queued
    diff0 = wslot - q_stat.e0.base;
    diff1 = wslot - q_stat.e1.base;
    hit   = ((q_stat.count != 2'd0) && ({1'b0, diff0} < q_stat.e0.len)) ||
            ((q_stat.count == 2'd2) && ({1'b0, diff1} < q_stat.e1.len));

    in_stall = hit || (q_stat.count == 2'd2);
    accept   = in_valid && !in_stall;
    done     = fill_b >= win;

    ram_wr.en   = accept;
    ram_wr.addr = wslot;
    ram_wr.data = {(nch > NCH_W'(3)) ? ch3_in : {WORD_BITS{1'b0}},
                   (nch > NCH_W'(2)) ? ch2_in : {WORD_BITS{1'b0}},
                   (nch > NCH_W'(1)) ? ch1_in : {WORD_BITS{1'b0}},
                   ch0_in};

    q_push     = accept && done;
    q_cmd.base = head_a;
    q_cmd.len  = win;

    head_next = head;
    fill_next = fill;
    if (accept) begin
      if (!done) begin
        head_next = head_a;
        fill_next = fill_b;
      end else if ((hop != '0) && (hop <= fill_b)) begin
        head_next = head_a + hop[PTR_W-1:0];
        fill_next = fill_b - hop;
      end else begin
        head_next = '0;
        fill_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

endmodule

@@ rtl/owf_queue.sv @@
// ----------------------------------------------------------------------------
// owf_queue
// Two-entry queue of pending windows between front and back.
// ----------------------------------------------------------------------------
module owf_queue import owf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      cmd,
  input  logic      pop,
  output q_status_t stat
);

  logic [1:0] count;
  cmd_t       e0;
  cmd_t       e1;

  assign stat.count = count;
  assign stat.e0    = e0;
  assign stat.e1    = e1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e0 <= (push && (count == 2'd1)) ? cmd : e1;
      if (push) begin
        e1 <= cmd;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        e0 <= cmd;
      end else begin
        e1 <= cmd;
      end
    end
  end

endmodule

@@ rtl/owf_back.sv @@
// ----------------------------------------------------------------------------
// owf_back
// Reads queued windows out of the sample store into a two-beat output buffer.
// ----------------------------------------------------------------------------
module owf_back import owf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  q_status_t            q_stat,
  output logic                 q_pop,
  output logic                 rd_en,
  output logic [PTR_W-1:0]     rd_addr,
  input  logic [SAMPLE_W-1:0]  rd_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output beat_t                out_beat
);

  logic [PTR_W-1:0] pos;
  logic             pend;
  logic [PTR_W-1:0] pend_pos;
  logic             pend_last;
  logic [1:0]       oc;
  beat_t            f0;
  beat_t            f1;
  beat_t            inb;
  logic             opop;
  logic             last;
  logic             room;

  always_comb begin
    opop      = (oc != 2'd0) && !out_stall;
    room      = (3'(oc) + 3'(pend)) <= (3'd1 + 3'(opop));
    rd_en     = (q_stat.count != 2'd0) && room;
    rd_addr   = q_stat.e0.base + pos;
    last      = ({1'b0, pos} + CNT_W'(1)) == q_stat.e0.len;
    q_pop     = rd_en && last;
    out_valid = oc != 2'd0;
    out_beat  = f0;
    inb.data  = rd_data;
    inb.pos   = pend_pos;
    inb.last  = pend_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      pend <= 1'b0;
      oc   <= '0;
    end else begin
      pend <= rd_en;
      oc   <= oc + 2'(pend) - 2'(opop);
      if (rd_en) begin
        pos <= last ? '0 : pos + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_pos  <= pos;
      pend_last <= last;
    end
    if (opop) begin
      f0 <= (pend && (oc == 2'd1)) ? inb : f1;
      if (pend) begin
        f1 <= inb;
      end
    end else if (pend) begin
      if (oc == 2'd0) begin
        f0 <= inb;
      end else begin
        f1 <= inb;
      end
    end
  end

endmodule

@@ rtl/overlapping_window_framer_core.sv @@
// ----------------------------------------------------------------------------
// overlapping_window_framer_core
// Sliding window framer: 64-entry sample ring; emits each completed window
// oldest first, then drops hop samples, or all when hop is 0 or too large.
//
//   channel  direction  handshake          payload
//   cfg      in         cfg_valid/ready    cfg_index, cfg_data
//   in       in         in_valid/stall     ch0_in..ch3_in
//   out      out        out_valid/stall    ch0_out..ch3_out, position,
//                                          last_of_window
//
// A window of N samples streams at one beat per cycle, while out_stall is
// low, from the store's registered read port through the output buffer. A
// new sample waits only while its ring slot is still to be read or two
// windows are queued. Reset is synchronous and needs no clearing pass.
// out_stall holds the two-beat output buffer.
// ----------------------------------------------------------------------------
module overlapping_window_framer_core import owf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WORD_BITS-1:0]  ch0_in,
  input  logic [WORD_BITS-1:0]  ch1_in,
  input  logic [WORD_BITS-1:0]  ch2_in,
  input  logic [WORD_BITS-1:0]  ch3_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WORD_BITS-1:0]  ch0_out,
  output logic [WORD_BITS-1:0]  ch1_out,
  output logic [WORD_BITS-1:0]  ch2_out,
  output logic [WORD_BITS-1:0]  ch3_out,
  output logic [PTR_W-1:0]      position,
  output logic                  last_of_window
);

  q_status_t           q_stat;
  logic                q_push;
  logic                q_pop;
  cmd_t                q_cmd;
  ram_wr_t             ram_wr;
  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  beat_t               out_beat;

  owf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ch0_in    (ch0_in),
    .ch1_in    (ch1_in),
    .ch2_in    (ch2_in),
    .ch3_in    (ch3_in),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .ram_wr    (ram_wr)
  );

  owf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .cmd  (q_cmd),
    .pop  (q_pop),
    .stat (q_stat)
  );

  owf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_store (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  owf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  assign ch0_out        = out_beat.data[0*WORD_BITS +: WORD_BITS];
  assign ch1_out        = out_beat.data[1*WORD_BITS +: WORD_BITS];
  assign ch2_out        = out_beat.data[2*WORD_BITS +: WORD_BITS];
  assign ch3_out        = out_beat.data[3*WORD_BITS +: WORD_BITS];
  assign position       = out_beat.pos;
  assign last_of_window = out_beat.last;

endmodule
